@@ design/pgf_pkg.sv @@
package pgf_pkg;

  localparam logic [7:0] GAIN_RESET = 8'd10;
  localparam int DIV_F_STEPS = 32;
  localparam int SQRT_S_STEPS = 25;
  localparam int DIV_D_STEPS = 29;
  localparam int SQRT_D_STEPS = 15;
  localparam int NSTEP = DIV_D_STEPS + SQRT_D_STEPS;
  localparam logic [14:0] DIR_ONE = 15'd16384;

  typedef struct packed {
    logic [49:0] rem;
    logic        q;
  } div_res_t;

  typedef struct packed {
    logic [27:0] rem;
    logic [24:0] root;
  } sqrt_res_t;

  typedef struct packed {
    logic        a1;
    logic        a2;
    logic        act;
    logic        sat;
    logic        zero;
    logic        negx;
    logic        negy;
    logic [49:0] d2;
    logic [49:0] sd;
    logic [7:0]  lowf;
    logic [49:0] rem_f;
    logic [31:0] q_f;
    logic [27:0] rem_s;
    logic [24:0] root_s;
    logic        xlsb;
    logic        ylsb;
    logic [49:0] rem_x;
    logic [49:0] rem_y;
    logic [29:0] q_x;
    logic [29:0] q_y;
    logic [27:0] rem_rx;
    logic [27:0] rem_ry;
    logic [24:0] root_x;
    logic [24:0] root_y;
  } pipe_t;

  // one restoring division step
  function automatic div_res_t div_step(logic [49:0] rem, logic nbit, logic [49:0] den);
    logic [50:0] r;
    div_res_t    res;
    r = {rem, nbit};
    if (r >= {1'b0, den}) begin
      res.rem = 50'(r - {1'b0, den});
      res.q   = 1'b1;
    end else begin
      res.rem = r[49:0];
      res.q   = 1'b0;
    end
    return res;
  endfunction

  // one digit of the integer square root
  function automatic sqrt_res_t sqrt_step(logic [27:0] rem, logic [24:0] root,
                                          logic [1:0] pair);
    logic [29:0] r;
    logic [29:0] t;
    sqrt_res_t   res;
    r = {rem, pair};
    t = {3'b0, root, 2'b01};
    if (r >= t) begin
      res.rem  = 28'(r - t);
      res.root = {root[23:0], 1'b1};
    end else begin
      res.rem  = r[27:0];
      res.root = {root[23:0], 1'b0};
    end
    return res;
  endfunction

endpackage

@@ design/pairwise_gravity_force_top.sv @@
// channel | valid     | ready     | payload
// in      | in_valid  | in_ready  | first_*, second_* (one body pair)
// out     | out_valid | out_ready | push_*, force_size, dir_*, separation
// cfg     | cfg_valid | cfg_ready | gravity_gain
//
// One pair per cycle while the output is not stalled (3 front stages, 45 step stages, output).
// Latency is set by the direction path: 29 division steps then 15 root steps.
// rst clears all valid bits and sets the gain register to 10.
// A stalled output freezes the whole pipeline; in_ready follows it.
module pairwise_gravity_force_top
  import pgf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         gravity_gain,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] first_x,
  input  logic signed [23:0] first_y,
  input  logic signed [23:0] second_x,
  input  logic signed [23:0] second_y,
  input  logic [15:0]        first_mass,
  input  logic [15:0]        second_mass,
  input  logic [22:0]        first_reach,
  input  logic [22:0]        second_reach,
  input  logic               first_attracts,
  input  logic               second_attracts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               push_second,
  output logic               push_first,
  output logic [31:0]        force_size,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic [23:0]        separation
);

  localparam int NS = NSTEP + 1;

  logic [7:0] gain;
  logic       adv;

  // front stage a
  logic        va;
  logic [24:0] ax_a, ay_a;
  logic        negx_a, negy_a, a1_a, a2_a;
  logic [22:0] reach_a;
  logic [15:0] m1_a, m2_a;
  // front stage b
  logic        vb;
  logic [49:0] ax2_b, ay2_b;
  logic [45:0] r2_b;
  logic [31:0] mm_b;
  logic        negx_b, negy_b, a1_b, a2_b;
  // front stage c
  logic        vc;
  logic [49:0] ax2_c, ay2_c, d2_c;
  logic [45:0] r2_c;
  logic [39:0] prod_c;
  logic        negx_c, negy_c, a1_c, a2_c;

  logic [NS-1:0] sv;
  pipe_t         st [NS];
  pipe_t         nx [NS];

  logic signed [24:0] dx, dy;
  logic [14:0] qx, qy;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_valid) begin
      gain <= gravity_gain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      sv        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      sv        <= {sv[NS-2:0], vc};
      out_valid <= sv[NS-1];
    end
  end

  assign dx = 25'(first_x) - 25'(second_x);
  assign dy = 25'(first_y) - 25'(second_y);

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_a    <= dx[24] ? 25'(-dx) : dx;
      ay_a    <= dy[24] ? 25'(-dy) : dy;
      negx_a  <= dx[24];
      negy_a  <= dy[24];
      reach_a <= (first_reach > second_reach) ? first_reach : second_reach;
      m1_a    <= first_mass;
      m2_a    <= second_mass;
      a1_a    <= first_attracts;
      a2_a    <= second_attracts;

      ax2_b  <= 50'(ax_a) * 50'(ax_a);
      ay2_b  <= 50'(ay_a) * 50'(ay_a);
      r2_b   <= 46'(reach_a) * 46'(reach_a);
      mm_b   <= 32'(m1_a) * 32'(m2_a);
      negx_b <= negx_a;
      negy_b <= negy_a;
      a1_b   <= a1_a;
      a2_b   <= a2_a;

      ax2_c  <= ax2_b;
      ay2_c  <= ay2_b;
      d2_c   <= ax2_b + ay2_b;
      r2_c   <= r2_b;
      prod_c <= 40'(gain) * 40'(mm_b);
      negx_c <= negx_b;
      negy_c <= negy_b;
      a1_c   <= a1_b;
      a2_c   <= a2_b;
    end
  end

  always_comb begin
    div_res_t  dr;
    sqrt_res_t sr;
    nx[0]        = '0;
    nx[0].a1     = a1_c;
    nx[0].a2     = a2_c;
    nx[0].act    = (a1_c || a2_c) && (d2_c <= {4'b0, r2_c});
    nx[0].zero   = (d2_c == '0);
    nx[0].sat    = (d2_c == '0) || ({18'b0, prod_c} >= {d2_c, 8'b0});
    nx[0].negx   = negx_c;
    nx[0].negy   = negy_c;
    nx[0].d2     = d2_c;
    nx[0].sd     = d2_c;
    nx[0].lowf   = prod_c[7:0];
    nx[0].rem_f  = {18'b0, prod_c[39:8]};
    nx[0].rem_x  = {1'b0, ax2_c[49:1]};
    nx[0].xlsb   = ax2_c[0];
    nx[0].rem_y  = {1'b0, ay2_c[49:1]};
    nx[0].ylsb   = ay2_c[0];
    for (int k = 1; k < NS; k++) begin
      nx[k] = st[k-1];
      if (k - 1 < DIV_F_STEPS) begin
        dr = div_step(st[k-1].rem_f, st[k-1].lowf[7], st[k-1].d2);
        nx[k].rem_f = dr.rem;
        nx[k].q_f   = {st[k-1].q_f[30:0], dr.q};
        nx[k].lowf  = {st[k-1].lowf[6:0], 1'b0};
      end
      if (k - 1 < SQRT_S_STEPS) begin
        sr = sqrt_step(st[k-1].rem_s, st[k-1].root_s, st[k-1].sd[49:48]);
        nx[k].rem_s  = sr.rem;
        nx[k].root_s = sr.root;
        nx[k].sd     = {st[k-1].sd[47:0], 2'b0};
      end
      if (k - 1 < DIV_D_STEPS) begin
        dr = div_step(st[k-1].rem_x, st[k-1].xlsb, st[k-1].d2);
        nx[k].rem_x = dr.rem;
        nx[k].q_x   = {st[k-1].q_x[28:0], dr.q};
        nx[k].xlsb  = 1'b0;
        dr = div_step(st[k-1].rem_y, st[k-1].ylsb, st[k-1].d2);
        nx[k].rem_y = dr.rem;
        nx[k].q_y   = {st[k-1].q_y[28:0], dr.q};
        nx[k].ylsb  = 1'b0;
      end else begin
        sr = sqrt_step(st[k-1].rem_rx, st[k-1].root_x, st[k-1].q_x[29:28]);
        nx[k].rem_rx = sr.rem;
        nx[k].root_x = sr.root;
        nx[k].q_x    = {st[k-1].q_x[27:0], 2'b0};
        sr = sqrt_step(st[k-1].rem_ry, st[k-1].root_y, st[k-1].q_y[29:28]);
        nx[k].rem_ry = sr.rem;
        nx[k].root_y = sr.root;
        nx[k].q_y    = {st[k-1].q_y[27:0], 2'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        st[k] <= nx[k];
      end
    end
  end

  assign qx = (st[NS-1].root_x[14:0] > DIR_ONE) ? DIR_ONE : st[NS-1].root_x[14:0];
  assign qy = (st[NS-1].root_y[14:0] > DIR_ONE) ? DIR_ONE : st[NS-1].root_y[14:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      separation  <= st[NS-1].root_s[24] ? 24'hFFFFFF : st[NS-1].root_s[23:0];
      push_second <= st[NS-1].act && st[NS-1].a1;
      push_first  <= st[NS-1].act && st[NS-1].a2;
      if (!st[NS-1].act) begin
        force_size <= '0;
      end else if (st[NS-1].sat) begin
        force_size <= 32'hFFFFFFFF;
      end else begin
        force_size <= st[NS-1].q_f;
      end
      if (!st[NS-1].act || st[NS-1].zero) begin
        dir_x <= '0;
        dir_y <= '0;
      end else begin
        dir_x <= st[NS-1].negx ? 16'(-{1'b0, qx}) : 16'({1'b0, qx});
        dir_y <= st[NS-1].negy ? 16'(-{1'b0, qy}) : 16'({1'b0, qy});
      end
    end
  end

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !push_first && !push_second) |->
      (force_size == '0 && dir_x == '0 && dir_y == '0))
    else $error("inactive pair carries force");

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dir_x <= 16'sd16384 && dir_x >= -16'sd16384 &&
                   dir_y <= 16'sd16384 && dir_y >= -16'sd16384))
    else $error("direction out of range");

  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    (out_valid && separation == '0 && (push_first || push_second)) |->
      (force_size == 32'hFFFFFFFF && dir_x == '0 && dir_y == '0))
    else $error("zero distance not saturated");

endmodule
